@@ hw/rtl/srsw_pkg.sv @@
// Shared constants, command codes and request/response types for the selective-repeat sender.
package srsw_pkg;

	// Default sizes of the sequence space and of the send window
	localparam int SEQ_SPACE_DEF   = 8;
	localparam int WINDOW_SIZE_DEF = 4;

	// Fixed field widths on the channels
	localparam int CMD_W  = 2;
	localparam int WORD_W = 64;
	localparam int SEQ_FW = 3;
	localparam int CNT_FW = 3;

	// Request kinds
	localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] payload_word;
		logic [SEQ_FW-1:0] seq_num;
		logic              checksum_ok;
	} srsw_req_t;

	typedef struct packed {
		logic              accepted;
		logic              emit_packet;
		logic [SEQ_FW-1:0] packet_seq;
		logic [WORD_W-1:0] packet_payload;
		logic              timer_start;
		logic              timer_stop;
		logic [SEQ_FW-1:0] timer_seq;
		logic [SEQ_FW-1:0] base_now;
		logic [CNT_FW-1:0] outstanding;
		logic              full_flag;
	} srsw_rsp_t;

endpackage

@@ hw/rtl/srsw_chan_if.sv @@
// Valid/ready channel carrying one request or response payload.
interface srsw_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/selective_repeat_sender_window_top.sv @@
// Selective-repeat ARQ sender window: payload store, window bookkeeping and result register.
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+-----------------------------------------------
//   req     | in  | valid/ready | cmd, payload_word, seq_num, checksum_ok
//   rsp     | out | valid/ready | accepted .. full_flag, one response per request
//
// A request is handled in two states: ST_IDLE accepts it and issues the payload store read,
// then ST_EXEC applies the command and loads the response register.
// An ack at the window base goes through ST_SLIDE, which steps the base past each acked entry
// and loads the response once the slide stops.
// Reset (arst_n low) empties the window and clears all acked marks at once.
// A waiting response stalls the next command only when it must load its own.
module selective_repeat_sender_window_top #(
	parameter int SEQ_SPACE   = srsw_pkg::SEQ_SPACE_DEF,
	parameter int WINDOW_SIZE = srsw_pkg::WINDOW_SIZE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	srsw_chan_if.sink    req,
	srsw_chan_if.source  rsp
);
	import srsw_pkg::*;

	localparam int WinCap   = (WINDOW_SIZE < SEQ_SPACE) ? WINDOW_SIZE : SEQ_SPACE;
	localparam int SeqW     = $clog2(SEQ_SPACE);
	localparam int CntW     = $clog2(WinCap + 1);
	localparam int ModSteps = 3;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SLIDE = 2'd2;

	logic [1:0]           state_q, state_d;
	logic [CMD_W-1:0]     cmd_q;
	logic [WORD_W-1:0]    word_q;
	logic [SeqW-1:0]      sq_q;
	logic                 ck_q;
	logic [SeqW-1:0]      next_seq_q, next_seq_d;
	logic [SeqW-1:0]      base_q, base_d;
	logic [CntW-1:0]      count_q, count_d;
	logic [SEQ_SPACE-1:0] acked_q;
	logic                 rsp_valid_q;
	srsw_rsp_t            rsp_q;

	logic                 acc;
	logic                 out_free;
	logic [SEQ_FW-1:0]    seq_red;
	logic [SeqW-1:0]      sq_in;
	logic [SeqW-1:0]      ofs;
	logic                 hit;
	logic                 send_ok;
	logic                 ack_set;
	logic                 ack_clr;
	logic [SeqW-1:0]      ack_idx;
	logic                 mem_we;
	logic                 load;
	logic [WORD_W-1:0]    rd_data;
	srsw_rsp_t            res;

	function automatic logic [SeqW-1:0] seq_inc(input logic [SeqW-1:0] v);
		return (int'(v) == SEQ_SPACE - 1) ? '0 : v + SeqW'(1);
	endfunction

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Reduce the incoming sequence number into the sequence space
	always_comb begin
		seq_red = req.data.seq_num;
		for (int k = 0; k < ModSteps; k++) begin
			if (int'(seq_red) >= SEQ_SPACE) begin
				seq_red = seq_red - SEQ_FW'(SEQ_SPACE);
			end
		end
	end
	assign sq_in = SeqW'(seq_red);

	// Distance of the acked entry from the window base
	always_comb begin
		if (sq_q >= base_q) begin
			ofs = sq_q - base_q;
		end else begin
			ofs = SeqW'({1'b0, sq_q} + (SeqW+1)'(SEQ_SPACE) - {1'b0, base_q});
		end
	end
	assign hit     = (count_q != '0) && ck_q && (int'(ofs) < int'(count_q));
	assign send_ok = int'(count_q) < WinCap;

	// Payload store; a send writes in ST_EXEC after its accept, before any later read
	srsw_pay_mem #(
		.DEPTH(SEQ_SPACE)
	) u_pay_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (next_seq_q),
		.wdata (word_q),
		.re    (acc),
		.raddr (sq_in),
		.rdata (rd_data)
	);

	// Apply the command, step the slide, build the response
	always_comb begin
		state_d    = state_q;
		next_seq_d = next_seq_q;
		base_d     = base_q;
		count_d    = count_q;
		ack_set    = 1'b0;
		ack_clr    = 1'b0;
		ack_idx    = sq_q;
		mem_we     = 1'b0;
		load       = 1'b0;
		res        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_SEND: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = ST_IDLE;
							if (send_ok) begin
								mem_we             = 1'b1;
								ack_clr            = 1'b1;
								ack_idx            = next_seq_q;
								next_seq_d         = seq_inc(next_seq_q);
								count_d            = count_q + CntW'(1);
								res.accepted       = 1'b1;
								res.emit_packet    = 1'b1;
								res.packet_seq     = SEQ_FW'(next_seq_q);
								res.packet_payload = word_q;
								res.timer_start    = 1'b1;
								res.timer_seq      = SEQ_FW'(next_seq_q);
							end
						end
					end
					CMD_ACK: begin
						if (hit && (sq_q == base_q)) begin
							ack_set = 1'b1;
							state_d = ST_SLIDE;
						end else if (out_free) begin
							load    = 1'b1;
							state_d = ST_IDLE;
							if (hit) begin
								ack_set        = 1'b1;
								res.timer_stop = 1'b1;
								res.timer_seq  = SEQ_FW'(sq_q);
							end
						end
					end
					CMD_TIMEOUT: begin
						if (out_free) begin
							load               = 1'b1;
							state_d            = ST_IDLE;
							res.emit_packet    = 1'b1;
							res.packet_seq     = SEQ_FW'(sq_q);
							res.packet_payload = rd_data;
							res.timer_start    = 1'b1;
							res.timer_seq      = SEQ_FW'(sq_q);
						end
					end
					default: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_SLIDE: begin
				if ((count_q != '0) && acked_q[base_q]) begin
					base_d  = seq_inc(base_q);
					count_d = count_q - CntW'(1);
				end else if (out_free) begin
					load           = 1'b1;
					state_d        = ST_IDLE;
					res.timer_stop = 1'b1;
					res.timer_seq  = SEQ_FW'(sq_q);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res.base_now    = SEQ_FW'(base_d);
		res.outstanding = CNT_FW'(count_d);
		res.full_flag   = int'(count_d) >= WinCap;
	end

	// Control state and window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_seq_q  <= '0;
			base_q      <= '0;
			count_q     <= '0;
			acked_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			next_seq_q <= next_seq_d;
			base_q     <= base_d;
			count_q    <= count_d;
			if (ack_set) begin
				acked_q[ack_idx] <= 1'b1;
			end else if (ack_clr) begin
				acked_q[ack_idx] <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted request and the pending response
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q  <= req.data.cmd;
			word_q <= req.data.payload_word;
			sq_q   <= sq_in;
			ck_q   <= req.data.checksum_ok;
		end
		if (load) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

@@ hw/rtl/srsw_pay_mem.sv @@
// Payload store: one write port, one read port with registered read data.
module srsw_pay_mem #(
	parameter int DEPTH = srsw_pkg::SEQ_SPACE_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [srsw_pkg::WORD_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [srsw_pkg::WORD_W-1:0] rdata
);
	import srsw_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Write the stored word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/srsw_chk.sv @@
// Port-level checks for the selective-repeat sender, bound to the top level.
module srsw_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input srsw_pkg::srsw_rsp_t rsp_data
);
	import srsw_pkg::*;

	// An accepted send emits its packet and starts the timer of that packet
	a_send_emits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.accepted |->
			rsp_data.emit_packet && rsp_data.timer_start &&
			(rsp_data.packet_seq == rsp_data.timer_seq))
		else $error("accepted send without matching emit and timer start");

	// Never start and stop a timer in the same response
	a_timer_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.timer_start && rsp_data.timer_stop))
		else $error("timer start and stop in one response");

	// No packet emitted means no timer start and cleared packet fields
	a_no_emit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.emit_packet |->
			!rsp_data.timer_start && (rsp_data.packet_seq == '0) &&
			(rsp_data.packet_payload == '0))
		else $error("packet fields set without emit");

	// One request at a time: ready drops after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

endmodule

bind selective_repeat_sender_window_top srsw_chk u_srsw_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

@@ tb/selective_repeat_sender_window_top_test.sv @@
// Testbench for the selective-repeat sender window: directed and random requests against a predictor.
module selective_repeat_sender_window_top_test;
	import srsw_pkg::*;

	localparam int SEQ_SPACE   = SEQ_SPACE_DEF;
	localparam int WINDOW_SIZE = WINDOW_SIZE_DEF;
	localparam int WIN_CAP     = (WINDOW_SIZE < SEQ_SPACE) ? WINDOW_SIZE : SEQ_SPACE;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int RESET_CYCLES  = 12;
	localparam int LONG_HOLD     = 150;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int RANDOM_ITEMS  = 1660;
	localparam int PRESSURE_REQS = 60;
	localparam int STEADY_ITEMS  = 200;

	logic clk = 1'b0;
	logic arst_n;

	srsw_chan_if #(.T(srsw_req_t)) req_ch ();
	srsw_chan_if #(.T(srsw_rsp_t)) rsp_ch ();

	selective_repeat_sender_window_top #(
		.SEQ_SPACE   (SEQ_SPACE),
		.WINDOW_SIZE (WINDOW_SIZE)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Window state as the predictor sees it
	int                win_next  = 0;
	int                win_base  = 0;
	int                win_count = 0;
	bit                win_acked   [SEQ_SPACE];
	bit                win_written [SEQ_SPACE];
	logic [WORD_W-1:0] win_store   [SEQ_SPACE];

	srsw_rsp_t expected_rsps[$];
	int        mismatch_count = 0;

	// Idling controls shared by the sender and the receiver
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_request = 1'b0;
	int hold_cnt = 0;
	int rx_gap = 0;
	int stall_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one request to the predicted window and return the response it causes
	function automatic srsw_rsp_t step_window(srsw_req_t r);
		srsw_rsp_t o;
		int        sq;
		int        ofs;
		o = '0;
		sq = int'(r.seq_num) % SEQ_SPACE;
		case (r.cmd)
			CMD_SEND: begin
				if (win_count < WIN_CAP) begin
					win_store[win_next] = r.payload_word;
					win_written[win_next] = 1'b1;
					win_acked[win_next] = 1'b0;
					o.accepted = 1'b1;
					o.emit_packet = 1'b1;
					o.packet_seq = SEQ_FW'(win_next);
					o.packet_payload = r.payload_word;
					o.timer_start = 1'b1;
					o.timer_seq = SEQ_FW'(win_next);
					win_next = (win_next + 1) % SEQ_SPACE;
					win_count++;
				end
			end
			CMD_ACK: begin
				if (win_count != 0 && r.checksum_ok) begin
					ofs = (sq + SEQ_SPACE - win_base) % SEQ_SPACE;
					if (ofs < win_count) begin
						win_acked[sq] = 1'b1;
						o.timer_stop = 1'b1;
						o.timer_seq = SEQ_FW'(sq);
						// slide the base past every consecutive acked entry
						if (sq == win_base) begin
							while (win_count > 0 && win_acked[win_base]) begin
								win_base = (win_base + 1) % SEQ_SPACE;
								win_count--;
							end
						end
					end
				end
			end
			CMD_TIMEOUT: begin
				o.emit_packet = 1'b1;
				o.packet_seq = SEQ_FW'(sq);
				o.packet_payload = win_store[sq];
				o.timer_start = 1'b1;
				o.timer_seq = SEQ_FW'(sq);
			end
			default: begin
			end
		endcase
		o.base_now = SEQ_FW'(win_base);
		o.outstanding = CNT_FW'(win_count);
		o.full_flag = (win_count >= WIN_CAP);
		return o;
	endfunction

	function automatic srsw_req_t make_req(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word,
			int seq, bit ck);
		srsw_req_t r;
		r.cmd = cmd;
		r.payload_word = word;
		r.seq_num = SEQ_FW'(seq);
		r.checksum_ok = ck;
		return r;
	endfunction

	// Draw a request, mostly well-formed for the current window; never time out an unwritten entry
	function automatic srsw_req_t pick_random_req();
		srsw_req_t r;
		int        roll;
		int        pool[$];
		r = make_req(CMD_SEND, {$urandom, $urandom}, $urandom_range(0, SEQ_SPACE - 1),
			1'($urandom_range(0, 1)));
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			r.cmd = CMD_SEND;
		end else if (roll < 82) begin
			r.cmd = CMD_ACK;
			if (win_count > 0 && $urandom_range(0, 9) < 8) begin
				r.seq_num = SEQ_FW'((win_base + $urandom_range(0, win_count - 1)) % SEQ_SPACE);
				r.checksum_ok = 1'b1;
			end
		end else if (roll < 97) begin
			for (int i = 0; i < SEQ_SPACE; i++) begin
				if (win_written[i])
					pool.push_back(i);
			end
			if (pool.size() > 0) begin
				r.cmd = CMD_TIMEOUT;
				r.seq_num = SEQ_FW'(pool[$urandom_range(0, pool.size() - 1)]);
			end
		end else begin
			r.cmd = CMD_UNUSED;
		end
		return r;
	endfunction

	// Offer one request, hold it until accepted, then record its predicted response
	task automatic issue_req(srsw_req_t r);
		int gap;
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		expected_rsps.push_back(step_window(r));
	endtask

	task automatic test_directed();
		// ack on an empty window and an unknown command
		issue_req(make_req(CMD_ACK, '1, 0, 1'b1));
		issue_req(make_req(CMD_UNUSED, '0, 7, 1'b0));
		// fill the window with extreme payloads, then get refused
		issue_req(make_req(CMD_SEND, '0, 0, 1'b0));
		issue_req(make_req(CMD_SEND, '1, 7, 1'b1));
		issue_req(make_req(CMD_SEND, 64'h5555_5555_5555_5555, 0, 1'b0));
		issue_req(make_req(CMD_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 7, 1'b1));
		issue_req(make_req(CMD_SEND, 64'h0123_4567_89AB_CDEF, 0, 1'b0));
		// bad checksum, outside the window, ack off the base twice
		issue_req(make_req(CMD_ACK, '0, 1, 1'b0));
		issue_req(make_req(CMD_ACK, '0, 5, 1'b1));
		issue_req(make_req(CMD_ACK, '0, 2, 1'b1));
		issue_req(make_req(CMD_ACK, '1, 2, 1'b1));
		// ack the base: slide by one only
		issue_req(make_req(CMD_ACK, '0, 0, 1'b1));
		// timeout outside and inside the window
		issue_req(make_req(CMD_TIMEOUT, '1, 0, 1'b1));
		issue_req(make_req(CMD_TIMEOUT, '0, 3, 1'b0));
		// slide past several acked entries, then empty the window
		issue_req(make_req(CMD_ACK, '0, 1, 1'b1));
		issue_req(make_req(CMD_ACK, '0, 3, 1'b1));
		// wrap the sequence space and ack in reverse order
		for (int i = 0; i < 4; i++)
			issue_req(make_req(CMD_SEND, {$urandom, $urandom}, i, 1'b0));
		for (int i = 7; i >= 4; i--)
			issue_req(make_req(CMD_ACK, '0, i, 1'b1));
		issue_req(make_req(CMD_UNUSED, {$urandom, $urandom}, 3, 1'b1));
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < RANDOM_ITEMS; i++)
			issue_req(pick_random_req());
	endtask

	// Hold the receiver off while requests keep coming so the block stalls its input
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < PRESSURE_REQS; i++)
			issue_req(pick_random_req());
	endtask

	task automatic test_steady_stream();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < STEADY_ITEMS; i++)
			issue_req(pick_random_req());
	endtask

	initial begin
		for (int i = 0; i < SEQ_SPACE; i++) begin
			win_acked[i] = 1'b0;
			win_written[i] = 1'b0;
			win_store[i] = '0;
		end
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix();
		test_backpressure();
		test_steady_stream();
		req_ch.valid <= 1'b0;

		// drain outstanding responses; the stall watchdog bounds this wait
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("selective_repeat_sender_window_top verification clean");
		else
			$display("selective_repeat_sender_window_top verification failed");
		$finish;
	end

	// Drive response ready: long hold on request, random stall bursts otherwise
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_cnt = LONG_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ch.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			rsp_ch.ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			rx_gap = $urandom_range(0, 10);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	function automatic void check_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Compare each accepted response with the oldest prediction
	always @(posedge clk) begin
		srsw_rsp_t want;
		srsw_rsp_t got;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.data;
			if (expected_rsps.size() == 0) begin
				$error("response with no request waiting");
				mismatch_count++;
			end else begin
				want = expected_rsps.pop_front();
				check_field("accepted", want.accepted, got.accepted);
				check_field("emit_packet", want.emit_packet, got.emit_packet);
				check_field("packet_seq", want.packet_seq, got.packet_seq);
				check_field("packet_payload", want.packet_payload, got.packet_payload);
				check_field("timer_start", want.timer_start, got.timer_start);
				check_field("timer_stop", want.timer_stop, got.timer_stop);
				check_field("timer_seq", want.timer_seq, got.timer_seq);
				check_field("base_now", want.base_now, got.base_now);
				check_field("outstanding", want.outstanding, got.outstanding);
				check_field("full_flag", want.full_flag, got.full_flag);
			end
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("selective_repeat_sender_window_top verification failed");
			$finish;
		end
	end

endmodule
